// ===== src/pcc_pkg.sv =====
// shared types and constants for the polygon / circle collision block
// no dependencies; used by pcc_alu and the top level
package pcc_pkg;

	// stream payload widths
	localparam int IN_TDATA_W  = 80;
	localparam int OUT_TDATA_W = 88;
	localparam int CMP_W       = 64;
	localparam int PROD_W      = 52;

	// result kinds
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_ONE  = 2'd1;
	localparam logic [1:0] KIND_TWO  = 2'd2;
	localparam logic [1:0] KIND_ACK  = 2'd3;

	// multiplier operands
	typedef struct packed {
		logic signed [25:0] a;
		logic signed [25:0] b;
	} mul_opnd_t;

	// compare-subtract status
	typedef struct packed {
		logic             ge;
		logic [CMP_W-1:0] diff;
	} cmp_res_t;

	// product / 2^24 rounded half away from zero
	function automatic logic signed [27:0] rnd24(input logic signed [PROD_W-1:0] p);
		logic [PROD_W-1:0] mag;
		logic [PROD_W-1:0] sum;
		logic [27:0]       q;
		mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
		sum = mag + PROD_W'(1 << 23);
		q   = sum[PROD_W-1:24];
		return p[PROD_W-1] ? -$signed(q) : $signed(q);
	endfunction

endpackage

// ===== src/pcc_vmem.sv =====
// vertex store: one write port, one registered read port
// no package dependencies
module pcc_vmem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [47:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [47:0]   rdata
);
	logic [47:0] mem_q [DEPTH];
	logic [47:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== src/pcc_alu.sv =====
// shared arithmetic unit: registered signed multiplier and a wide compare-subtract
// depends on pcc_pkg
module pcc_alu (
	input  logic                            clk,
	input  pcc_pkg::mul_opnd_t              mul_in,
	output logic signed [pcc_pkg::PROD_W-1:0] prod,
	input  logic [pcc_pkg::CMP_W-1:0]       cmp_a,
	input  logic [pcc_pkg::CMP_W-1:0]       cmp_b,
	output pcc_pkg::cmp_res_t               cmp_out
);
	import pcc_pkg::*;

	logic signed [PROD_W-1:0] prod_s1;

	// multiplier with result register
	always_ff @(posedge clk) begin
		prod_s1 <= mul_in.a * mul_in.b;
	end
	assign prod = prod_s1;

	// one compare-subtract step
	always_comb begin
		cmp_out.ge   = (cmp_a >= cmp_b);
		cmp_out.diff = cmp_a - cmp_b;
	end
endmodule

// ===== src/polygon_circle_collision_top.sv =====
// top level of the polygon / circle collision block: sequencer and datapath registers
// depends on pcc_pkg, pcc_alu and pcc_vmem
//
// A vertex load (tuser 0) writes one slot and returns a load acknowledge. A query
// (tuser 1) walks edges in order on one shared multiplier and one compare-subtract
// unit that retires one quotient or root bit per cycle: a setup step, the projection
// test on each edge, a division and a distance check for an edge that passes it, then,
// if an edge was hit, the unit normal (length normalize, square root, two 16-step
// divisions), and last the loading of the result. The block takes no new item until
// its result has been loaded into the output register.
module polygon_circle_collision_top #(
	parameter int MAX_VERTICES = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// vertex_index[5:0], x_coord[29:6], y_coord[53:30], radius[76:54], zero pad
	input  logic [pcc_pkg::IN_TDATA_W-1:0]     s_tdata,
	// mode[0]
	input  logic [0:0]                         s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// point_x[23:0], point_y[47:24], normal_x[63:48], normal_y[79:64],
	// edge_index[85:80], zero pad
	output logic [pcc_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// hit_kind[1:0]
	output logic [1:0]                         m_tuser,
	input  logic                               cfg_we,
	input  logic [6:0]                         cfg_data
);
	import pcc_pkg::*;

	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_R2   = 5'd1;
	localparam logic [4:0] ST_R2W  = 5'd2;
	localparam logic [4:0] ST_RDP  = 5'd3;
	localparam logic [4:0] ST_RDQ  = 5'd4;
	localparam logic [4:0] ST_LATQ = 5'd5;
	localparam logic [4:0] ST_M0   = 5'd6;
	localparam logic [4:0] ST_M1   = 5'd7;
	localparam logic [4:0] ST_M2   = 5'd8;
	localparam logic [4:0] ST_M3   = 5'd9;
	localparam logic [4:0] ST_M4   = 5'd10;
	localparam logic [4:0] ST_CHK  = 5'd11;
	localparam logic [4:0] ST_TDIV = 5'd12;
	localparam logic [4:0] ST_O0   = 5'd13;
	localparam logic [4:0] ST_O1   = 5'd14;
	localparam logic [4:0] ST_O2   = 5'd15;
	localparam logic [4:0] ST_E0   = 5'd16;
	localparam logic [4:0] ST_E1   = 5'd17;
	localparam logic [4:0] ST_E2   = 5'd18;
	localparam logic [4:0] ST_E3   = 5'd19;
	localparam logic [4:0] ST_HIT  = 5'd20;
	localparam logic [4:0] ST_NEXT = 5'd21;
	localparam logic [4:0] ST_N0   = 5'd22;
	localparam logic [4:0] ST_N1   = 5'd23;
	localparam logic [4:0] ST_N2   = 5'd24;
	localparam logic [4:0] ST_N3   = 5'd25;
	localparam logic [4:0] ST_NSH  = 5'd26;
	localparam logic [4:0] ST_SQ   = 5'd27;
	localparam logic [4:0] ST_DVI  = 5'd28;
	localparam logic [4:0] ST_DV   = 5'd29;
	localparam logic [4:0] ST_DONE = 5'd30;

	// input fields
	logic               in_mode;
	logic [5:0]         in_idx;
	logic signed [23:0] in_x;
	logic signed [23:0] in_y;
	logic [22:0]        in_r;
	assign in_mode = s_tuser[0];
	assign in_idx  = s_tdata[5:0];
	assign in_x    = s_tdata[29:6];
	assign in_y    = s_tdata[53:30];
	assign in_r    = s_tdata[76:54];

	logic [4:0]  state_q;
	logic [6:0]  vcount_q;
	logic [6:0]  edge_q;
	logic [1:0]  hits_q;
	logic [1:0]  kind_q;
	logic [4:0]  cnt_q;
	logic [4:0]  k_q;
	logic        comp_q;

	logic signed [23:0] cx_q, cy_q, px_q, py_q, hx_q, hy_q;
	logic signed [23:0] h1x_q, h1y_q, sx_q, sy_q;
	logic [5:0]         first_q;
	logic [22:0]        r_q;
	logic [45:0]        r2_q;
	logic signed [24:0] dx_q, dy_q, ex_q, ey_q, fdx_q, fdy_q;
	logic signed [PROD_W-1:0] len2_q, dot_q;
	logic [24:0]        t_q;
	logic [CMP_W-1:0]   rem_q;
	logic [61:0]        res_q;
	logic [60:0]        bit_q;
	logic [15:0]        quo_q;
	logic signed [15:0] ux_q, uy_q;

	logic                 m_tvalid_q;
	logic [1:0]           kind_out_q;
	logic signed [23:0]   opx_q, opy_q;
	logic signed [15:0]   onx_q, ony_q;
	logic [5:0]           oedge_q;

	// shared unit hookup
	mul_opnd_t                mul_in;
	logic signed [PROD_W-1:0] prod;
	logic [CMP_W-1:0]         cmp_a, cmp_b;
	cmp_res_t                 cmp_out;

	pcc_alu u_alu (
		.clk     (clk),
		.mul_in  (mul_in),
		.prod    (prod),
		.cmp_a   (cmp_a),
		.cmp_b   (cmp_b),
		.cmp_out (cmp_out)
	);

	// vertex store
	logic          wr_en;
	logic [AW-1:0] rd_addr;
	logic [47:0]   rd_data;
	logic [6:0]    edge_inc;
	logic [6:0]    edge_nxt;

	assign s_tready = (state_q == ST_IDLE);
	assign wr_en    = s_tvalid && s_tready && !in_mode && (32'(in_idx) < MAX_VERTICES);
	assign edge_inc = edge_q + 7'd1;
	assign edge_nxt = (edge_inc == vcount_q) ? 7'd0 : edge_inc;
	assign rd_addr  = (state_q == ST_RDQ) ? AW'(edge_nxt) : AW'(edge_q);

	pcc_vmem #(.DEPTH(MAX_VERTICES), .AW(AW)) u_vmem (
		.clk   (clk),
		.we    (wr_en),
		.waddr (AW'(in_idx)),
		.wdata ({in_y, in_x}),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	logic signed [23:0] rd_x, rd_y;
	assign rd_x = rd_data[23:0];
	assign rd_y = rd_data[47:24];

	// multiplier operand select
	always_comb begin
		mul_in.a = '0;
		mul_in.b = '0;
		case (state_q)
			ST_R2: begin
				mul_in.a = 26'(r_q);
				mul_in.b = 26'(r_q);
			end
			ST_M0, ST_N0: begin
				mul_in.a = 26'(dx_q);
				mul_in.b = 26'(dx_q);
			end
			ST_M1, ST_N1: begin
				mul_in.a = 26'(dy_q);
				mul_in.b = 26'(dy_q);
			end
			ST_M2: begin
				mul_in.a = 26'(dx_q);
				mul_in.b = 26'(ex_q);
			end
			ST_M3: begin
				mul_in.a = 26'(dy_q);
				mul_in.b = 26'(ey_q);
			end
			ST_O0: begin
				mul_in.a = 26'(dx_q);
				mul_in.b = $signed({1'b0, t_q});
			end
			ST_O1: begin
				mul_in.a = 26'(dy_q);
				mul_in.b = $signed({1'b0, t_q});
			end
			ST_E1: begin
				mul_in.a = 26'(ex_q);
				mul_in.b = 26'(ex_q);
			end
			ST_E2: begin
				mul_in.a = 26'(ey_q);
				mul_in.b = 26'(ey_q);
			end
			default: begin
				mul_in.a = '0;
				mul_in.b = '0;
			end
		endcase
	end

	// compare-subtract operand select
	always_comb begin
		cmp_a = rem_q;
		cmp_b = '0;
		case (state_q)
			ST_TDIV: begin
				cmp_a = rem_q << 1;
				cmp_b = CMP_W'($unsigned(len2_q));
			end
			ST_SQ: begin
				cmp_b = CMP_W'(res_q) + CMP_W'(bit_q);
			end
			ST_DV: begin
				cmp_b = CMP_W'(res_q[30:0]) << cnt_q;
			end
			default: begin
				cmp_b = '0;
			end
		endcase
	end

	// normal division setup
	logic signed [24:0] div_src;
	logic [24:0]        div_mag;
	logic [CMP_W-1:0]   div_num;
	logic [5:0]         div_shift;
	logic [PROD_W-1:0]  dist_u;
	logic signed [27:0] rnd_p;
	assign div_src   = comp_q ? dy_q : dx_q;
	assign div_mag   = div_src[24] ? 25'(-div_src) : 25'(div_src);
	assign div_shift = 6'(k_q) + 6'd14;
	assign div_num   = (CMP_W'(div_mag) << div_shift) + CMP_W'(res_q[30:1]);
	assign dist_u    = $unsigned(dot_q);
	assign rnd_p     = rnd24(prod);

	// vertex count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= 7'd2;
		end else if (cfg_we) begin
			if (cfg_data < 7'd2) begin
				vcount_q <= 7'd2;
			end else if (32'(cfg_data) > MAX_VERTICES) begin
				vcount_q <= 7'(MAX_VERTICES);
			end else begin
				vcount_q <= cfg_data;
			end
		end
	end

	// sequencer control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
			edge_q     <= '0;
			hits_q     <= '0;
			kind_q     <= KIND_NONE;
			cnt_q      <= '0;
			k_q        <= '0;
			comp_q     <= 1'b0;
		end else begin
			// result taken while no new one is being loaded
			if (m_tvalid_q && m_tready && state_q != ST_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						edge_q <= '0;
						hits_q <= '0;
						if (in_mode) begin
							state_q <= ST_R2;
						end else begin
							kind_q  <= KIND_ACK;
							state_q <= ST_DONE;
						end
					end
				end
				ST_R2:   state_q <= ST_R2W;
				ST_R2W:  state_q <= ST_RDP;
				ST_RDP:  state_q <= ST_RDQ;
				ST_RDQ:  state_q <= ST_LATQ;
				ST_LATQ: state_q <= ST_M0;
				ST_M0:   state_q <= ST_M1;
				ST_M1:   state_q <= ST_M2;
				ST_M2:   state_q <= ST_M3;
				ST_M3:   state_q <= ST_M4;
				ST_M4:   state_q <= ST_CHK;
				ST_CHK: begin
					cnt_q <= 5'd23;
					if (len2_q == 0 || dot_q < 0 || dot_q > len2_q) begin
						state_q <= ST_NEXT;
					end else begin
						state_q <= ST_TDIV;
					end
				end
				ST_TDIV: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) begin
						state_q <= ST_O0;
					end
				end
				ST_O0: state_q <= ST_O1;
				ST_O1: state_q <= ST_O2;
				ST_O2: state_q <= ST_E0;
				ST_E0: state_q <= ST_E1;
				ST_E1: state_q <= ST_E2;
				ST_E2: state_q <= ST_E3;
				ST_E3: state_q <= ST_HIT;
				ST_HIT: begin
					if (dist_u <= PROD_W'(r2_q)) begin
						hits_q <= hits_q + 2'd1;
					end
					state_q <= ST_NEXT;
				end
				ST_NEXT: begin
					if (hits_q == 2'd2 || edge_inc == vcount_q) begin
						if (hits_q == 2'd0) begin
							kind_q  <= KIND_NONE;
							state_q <= ST_DONE;
						end else begin
							kind_q  <= (hits_q == 2'd1) ? KIND_ONE : KIND_TWO;
							state_q <= ST_N0;
						end
					end else begin
						edge_q  <= edge_inc;
						state_q <= ST_RDP;
					end
				end
				ST_N0: state_q <= ST_N1;
				ST_N1: state_q <= ST_N2;
				ST_N2: state_q <= ST_N3;
				ST_N3: begin
					k_q <= '0;
					state_q <= (rem_q == 0) ? ST_DONE : ST_NSH;
				end
				ST_NSH: begin
					if (rem_q[63:60] == 4'd0) begin
						k_q <= k_q + 5'd1;
					end else begin
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					if (bit_q[0]) begin
						comp_q  <= 1'b0;
						state_q <= ST_DVI;
					end
				end
				ST_DVI: begin
					cnt_q   <= 5'd15;
					state_q <= ST_DV;
				end
				ST_DV: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) begin
						comp_q  <= 1'b1;
						state_q <= comp_q ? ST_DONE : ST_DVI;
					end
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cx_q <= in_x;
				cy_q <= in_y;
				r_q  <= in_r;
				ux_q <= '0;
				uy_q <= '0;
			end
			ST_R2W: r2_q <= 46'($unsigned(prod));
			ST_RDQ: begin
				px_q <= rd_x;
				py_q <= rd_y;
			end
			ST_LATQ: begin
				dx_q <= 25'(rd_x) - 25'(px_q);
				dy_q <= 25'(rd_y) - 25'(py_q);
				ex_q <= 25'(cx_q) - 25'(px_q);
				ey_q <= 25'(cy_q) - 25'(py_q);
			end
			ST_M1: len2_q <= prod;
			ST_M2: len2_q <= len2_q + prod;
			ST_M3: dot_q  <= prod;
			ST_M4: dot_q  <= dot_q + prod;
			ST_CHK: begin
				// parameter of one only when the projection lands on the end vertex
				if (dot_q == len2_q) begin
					t_q   <= 25'd1;
					rem_q <= '0;
				end else begin
					t_q   <= 25'd0;
					rem_q <= CMP_W'($unsigned(dot_q));
				end
			end
			ST_TDIV: begin
				t_q   <= {t_q[23:0], cmp_out.ge};
				rem_q <= cmp_out.ge ? cmp_out.diff : (rem_q << 1);
			end
			ST_O1: hx_q <= 24'(28'(px_q) + rnd_p);
			ST_O2: hy_q <= 24'(28'(py_q) + rnd_p);
			ST_E0: begin
				ex_q <= 25'(cx_q) - 25'(hx_q);
				ey_q <= 25'(cy_q) - 25'(hy_q);
			end
			ST_E2: dot_q <= prod;
			ST_E3: dot_q <= dot_q + prod;
			ST_HIT: begin
				if (dist_u <= PROD_W'(r2_q)) begin
					if (hits_q == 2'd0) begin
						h1x_q   <= hx_q;
						h1y_q   <= hy_q;
						first_q <= edge_q[5:0];
						fdx_q   <= dx_q;
						fdy_q   <= dy_q;
					end else begin
						sx_q <= px_q;
						sy_q <= py_q;
						// rotated difference of the two contact points
						dx_q <= 25'(h1y_q) - 25'(hy_q);
						dy_q <= 25'(hx_q) - 25'(h1x_q);
					end
				end
			end
			ST_NEXT: begin
				if (hits_q == 2'd1 && edge_inc == vcount_q) begin
					dx_q <= -fdy_q;
					dy_q <= fdx_q;
				end
			end
			ST_N1: rem_q <= CMP_W'($unsigned(prod));
			ST_N2: rem_q <= rem_q + CMP_W'($unsigned(prod));
			ST_NSH: begin
				if (rem_q[63:60] == 4'd0) begin
					rem_q <= rem_q << 2;
				end else begin
					res_q <= '0;
					bit_q <= 61'd1 << 60;
				end
			end
			ST_SQ: begin
				if (cmp_out.ge) begin
					rem_q <= cmp_out.diff;
					res_q <= (res_q >> 1) + 62'(bit_q);
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			ST_DVI: begin
				rem_q <= div_num;
				quo_q <= '0;
			end
			ST_DV: begin
				quo_q <= {quo_q[14:0], cmp_out.ge};
				if (cmp_out.ge) begin
					rem_q <= cmp_out.diff;
				end
				if (cnt_q == 5'd0) begin
					if (comp_q) begin
						uy_q <= div_src[24] ? -$signed({quo_q[14:0], cmp_out.ge})
						                    : $signed({quo_q[14:0], cmp_out.ge});
					end else begin
						ux_q <= div_src[24] ? -$signed({quo_q[14:0], cmp_out.ge})
						                    : $signed({quo_q[14:0], cmp_out.ge});
					end
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!m_tvalid_q || m_tready)) begin
			kind_out_q <= kind_q;
			opx_q      <= '0;
			opy_q      <= '0;
			onx_q      <= '0;
			ony_q      <= '0;
			oedge_q    <= '0;
			if (kind_q == KIND_ONE) begin
				opx_q   <= h1x_q;
				opy_q   <= h1y_q;
				onx_q   <= ux_q;
				ony_q   <= uy_q;
				oedge_q <= first_q;
			end else if (kind_q == KIND_TWO) begin
				opx_q <= sx_q;
				opy_q <= sy_q;
				onx_q <= ux_q;
				ony_q <= uy_q;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = kind_out_q;
	assign m_tdata  = {2'b00, oedge_q, ony_q, onx_q, opy_q, opx_q};

	// checks on the sequencer
	a_query_start: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser[0]) |=> (state_q == ST_R2))
		else $error("query accept did not start the walk");
	a_edge_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RDP) |-> (edge_q < vcount_q))
		else $error("edge counter beyond vertex count");
	a_hits_max: assert property (@(posedge clk) disable iff (!arst_n)
		(hits_q != 2'd3))
		else $error("more than two hits recorded");
	a_norm_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_N0) |-> (kind_q == KIND_ONE || kind_q == KIND_TWO))
		else $error("normal computed without a hit");
endmodule

// ===== tb/polygon_circle_collision_top_tb.sv =====
// testbench for polygon_circle_collision_top: vertex loads and circle queries on a stream port
// depends on pcc_pkg and the block's rtl; a scoreboard class predicts each result
`timescale 1ns / 100ps

module polygon_circle_collision_top_tb;
	import pcc_pkg::*;

	localparam int NVERT = 64;
	localparam longint CYCLE_LIMIT = 20000000;
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// one expected result
	typedef struct {
		logic [1:0]  kind;
		logic [23:0] px;
		logic [23:0] py;
		logic [15:0] nx;
		logic [15:0] ny;
		logic [5:0]  edge_no;
	} hit_t;

	// predictor of the collision walk plus the queue of expected hits
	class hit_scoreboard;
		longint vx[NVERT];
		longint vy[NVERT];
		int     count;
		hit_t   pending_hits[$];
		int     errors;
		int     n_loads, n_queries;
		int     n_kind[4];

		function new();
			count = 2;
			errors = 0;
			n_loads = 0;
			n_queries = 0;
			foreach (n_kind[i]) n_kind[i] = 0;
			foreach (vx[i]) begin
				vx[i] = 0;
				vy[i] = 0;
			end
		endfunction

		function void set_count(logic [6:0] v);
			count = (v < 2) ? 2 : (v > NVERT) ? NVERT : int'(v);
		endfunction

		function longint unsigned isqrt(longint unsigned v);
			longint unsigned res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v -= res + b;
					res = (res >> 1) + b;
				end else
					res >>= 1;
				b >>= 2;
			end
			return res;
		endfunction

		// num / den rounded half away from zero
		function longint rdiv(longint num, longint den);
			longint mag, q;
			mag = (num < 0) ? -num : num;
			q = (mag + den / 2) / den;
			return (num < 0) ? -q : q;
		endfunction

		// Q1.14 unit vector, zero vector stays zero
		function void unit(longint ax, longint ay, output longint ux, output longint uy);
			longint unsigned len2, root;
			int k;
			len2 = longint'(ax * ax) + longint'(ay * ay);
			k = 0;
			if (len2 == 0) begin
				ux = 0;
				uy = 0;
				return;
			end
			while (((len2 << (2 * (k + 1))) >> (2 * (k + 1))) == len2 &&
				(len2 << (2 * (k + 1))) < (64'd1 << 62))
				k++;
			root = isqrt(len2 << (2 * k));
			ux = rdiv(ax * (longint'(1) << (14 + k)), longint'(root));
			uy = rdiv(ay * (longint'(1) << (14 + k)), longint'(root));
		endfunction

		// projection of the centre onto one edge; true on a hit
		function bit edge_test(longint px, longint py, longint qx, longint qy,
				longint cx, longint cy, longint r2, output longint hx, output longint hy);
			longint dx, dy, len2, dot, rem, t, ex, ey;
			dx = qx - px;
			dy = qy - py;
			len2 = dx * dx + dy * dy;
			dot = dx * (cx - px) + dy * (cy - py);
			hx = 0;
			hy = 0;
			if (len2 == 0 || dot < 0 || dot > len2) return 0;
			rem = dot;
			t = 0;
			if (rem >= len2) begin
				t = 1;
				rem -= len2;
			end
			for (int i = 0; i < 24; i++) begin
				rem <<= 1;
				t <<= 1;
				if (rem >= len2) begin
					rem -= len2;
					t |= 1;
				end
			end
			hx = px + rdiv(dx * t, longint'(1) << 24);
			hy = py + rdiv(dy * t, longint'(1) << 24);
			ex = cx - hx;
			ey = cy - hy;
			return (ex * ex + ey * ey) <= r2;
		endfunction

		// accepted input transaction: update the store or walk the edges
		function void note(logic mode, logic [5:0] idx, logic signed [23:0] x,
				logic signed [23:0] y, logic [22:0] r);
			hit_t   h;
			longint hx, hy, h1x, h1y, h2x, h2y, nx, ny, r2;
			int     hits, e1, e2, nxt;
			h = '{default: '0};
			hits = 0;
			e1 = 0;
			e2 = 0;
			h1x = 0; h1y = 0; h2x = 0; h2y = 0;
			if (mode == MODE_LOAD) begin
				vx[idx] = x;
				vy[idx] = y;
				h.kind = KIND_ACK;
				n_loads++;
			end else begin
				n_queries++;
				r2 = longint'(r) * longint'(r);
				for (int i = 0; i < count && hits < 2; i++) begin
					nxt = (i + 1 == count) ? 0 : i + 1;
					if (edge_test(vx[i], vy[i], vx[nxt], vy[nxt], x, y, r2, hx, hy)) begin
						if (hits == 0) begin
							h1x = hx; h1y = hy; e1 = i;
						end else begin
							h2x = hx; h2y = hy; e2 = i;
						end
						hits++;
					end
				end
				if (hits == 1) begin
					nxt = (e1 + 1 == count) ? 0 : e1 + 1;
					unit(-(vy[nxt] - vy[e1]), vx[nxt] - vx[e1], nx, ny);
					h.kind = KIND_ONE;
					h.px = h1x[23:0];
					h.py = h1y[23:0];
					h.nx = nx[15:0];
					h.ny = ny[15:0];
					h.edge_no = e1[5:0];
				end else if (hits == 2) begin
					unit(-(h2y - h1y), h2x - h1x, nx, ny);
					h.kind = KIND_TWO;
					h.px = vx[e2][23:0];
					h.py = vy[e2][23:0];
					h.nx = nx[15:0];
					h.ny = ny[15:0];
				end
			end
			pending_hits.push_back(h);
		endfunction

		function void report(string what);
			$display("mismatch at %0t: %s", $time, what);
			errors++;
		endfunction

		// accepted result transaction against the oldest expectation
		function void check(logic [1:0] kind, logic [OUT_TDATA_W-1:0] d);
			hit_t e;
			if (pending_hits.size() == 0) begin
				report($sformatf("unexpected result kind %0d", kind));
				return;
			end
			e = pending_hits.pop_front();
			n_kind[e.kind]++;
			if (kind !== e.kind) report($sformatf("hit_kind %0d, want %0d", kind, e.kind));
			if (d[23:0] !== e.px) report($sformatf("point_x %h, want %h", d[23:0], e.px));
			if (d[47:24] !== e.py) report($sformatf("point_y %h, want %h", d[47:24], e.py));
			if (d[63:48] !== e.nx) report($sformatf("normal_x %h, want %h", d[63:48], e.nx));
			if (d[79:64] !== e.ny) report($sformatf("normal_y %h, want %h", d[79:64], e.ny));
			if (d[85:80] !== e.edge_no)
				report($sformatf("edge_index %0d, want %0d", d[85:80], e.edge_no));
			if (d[OUT_TDATA_W-1:86] !== '0) report("nonzero pad bits");
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic [0:0]             s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [1:0]             m_tuser;
	logic                   cfg_we;
	logic [6:0]             cfg_data;

	hit_scoreboard sb;
	longint        cycles;
	int            n_sent;
	bit            tx_steady;
	bit            rx_steady;
	bit            held_off;

	polygon_circle_collision_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic logic signed [23:0] sat24(longint v);
		if (v > 8388607) return 24'sd8388607;
		if (v < -8388608) return -24'sd8388608;
		return v[23:0];
	endfunction

	// one input transaction, after a random gap
	task automatic send(logic mode, logic [5:0] idx, logic signed [23:0] x,
			logic signed [23:0] y, logic [22:0] r);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			@(negedge clk) s_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser = mode;
		s_tdata = '0;
		s_tdata[5:0] = idx;
		s_tdata[29:6] = x;
		s_tdata[53:30] = y;
		s_tdata[76:54] = r;
		do @(posedge clk); while (!s_tready);
		sb.note(mode, idx, x, y, r);
		n_sent++;
	endtask

	// hold the sender until every result is back
	task automatic drain();
		@(negedge clk) s_tvalid = 1'b0;
		while (sb.pending_hits.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_vertex_count(logic [6:0] v);
		drain();
		cfg_we = 1'b1;
		cfg_data = v;
		@(negedge clk) cfg_we = 1'b0;
		sb.set_count(v);
	endtask

	// result side: random stalls, one long hold-off
	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held_off && sb.n_queries > 400) begin
				held_off = 1;
				stall = 600;
			end else
				stall = rx_steady ? 0 : $urandom_range(0, 11);
			if ($urandom_range(0, 40) == 0) rx_steady = !rx_steady;
			if (stall > 0) begin
				@(negedge clk) m_tready = 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk) m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
			sb.check(m_tuser, m_tdata);
		end
	end

	// stimulus
	initial begin
		longint lx[NVERT], ly[NVERT];
		longint ccx, ccy, span, ex, ey, t;
		int     n, e, nq;
		logic [6:0] cv;
		sb = new();
		cycles = 0;
		n_sent = 0;
		tx_steady = 0;
		rx_steady = 0;
		held_off = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = MODE_LOAD;
		cfg_we = 1'b0;
		cfg_data = 7'd2;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// fill every slot so no query reads an unwritten one
		for (int i = 0; i < NVERT; i++)
			send(MODE_LOAD, i[5:0], sat24($signed($urandom_range(0, 4095)) - 2048),
				sat24($signed($urandom_range(0, 4095)) - 2048), '0);

		// extreme segment walked both ways: two hits at one point, zero normal
		send(MODE_LOAD, 6'd0, -24'sd8388608, -24'sd8388608, '0);
		send(MODE_LOAD, 6'd1, 24'sd8388607, 24'sd8388607, 23'h7fffff);
		send(MODE_QUERY, 6'd63, 24'sd0, 24'sd0, 23'h7fffff);
		send(MODE_QUERY, 6'd0, 24'sd8388607, -24'sd8388608, 23'd0);
		send(MODE_QUERY, 6'd0, -24'sd8388608, -24'sd8388608, 23'd0);
		// zero-length edge never hits
		send(MODE_LOAD, 6'd1, -24'sd8388608, -24'sd8388608, '0);
		send(MODE_QUERY, 6'd0, -24'sd8388608, -24'sd8388608, 23'h7fffff);
		// triangle: single hit, outside, two hits at a corner, zero radius on an edge
		set_vertex_count(7'd3);
		send(MODE_LOAD, 6'd0, 24'sd0, 24'sd0, '0);
		send(MODE_LOAD, 6'd1, 24'sd25600, 24'sd0, '0);
		send(MODE_LOAD, 6'd2, 24'sd0, 24'sd25600, '0);
		send(MODE_QUERY, 6'd0, 24'sd12800, -24'sd256, 23'd512);
		send(MODE_QUERY, 6'd0, 24'sd90000, 24'sd90000, 23'd256);
		send(MODE_QUERY, 6'd0, 24'sd25600, 24'sd0, 23'd300);
		send(MODE_QUERY, 6'd0, 24'sd12800, 24'sd12800, 23'd0);
		// counts below and above the legal range
		set_vertex_count(7'd0);
		send(MODE_QUERY, 6'd0, 24'sd12800, 24'sd100, 23'd200);
		set_vertex_count(7'd127);
		send(MODE_QUERY, 6'd0, 24'sd12800, 24'sd100, 23'd200);
		drain();

		// random polygons with queries aimed near their edges
		while (n_sent < 1170) begin
			case ($urandom_range(0, 19))
				0:       cv = 7'($urandom_range(0, 127));
				1:       cv = 7'd64;
				2:       cv = 7'd2;
				default: cv = 7'($urandom_range(3, 8));
			endcase
			set_vertex_count(cv);
			n = sb.count;
			tx_steady = ($urandom_range(0, 4) == 0);
			span = ($urandom_range(0, 5) == 0) ? $urandom_range(1 << 16, 1 << 21)
				: $urandom_range(64, 1 << 13);
			ccx = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
			ccy = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
			for (int i = 0; i < n; i++) begin
				lx[i] = sat24(ccx + $signed($urandom_range(0, 2 * span)) - span);
				ly[i] = sat24(ccy + $signed($urandom_range(0, 2 * span)) - span);
				if ($urandom_range(0, 30) == 0 && i > 0) begin
					lx[i] = lx[i - 1];
					ly[i] = ly[i - 1];
				end
			end
			for (int i = 0; i < n; i++)
				send(MODE_LOAD, i[5:0], 24'(lx[i]), 24'(ly[i]), 23'($urandom));
			nq = (n > 16) ? 3 : $urandom_range(4, 12);
			for (int q = 0; q < nq; q++) begin
				if ($urandom_range(0, 9) == 0) begin
					// noise: anything at all
					send(MODE_QUERY, 6'($urandom), 24'($urandom), 24'($urandom), 23'($urandom));
					continue;
				end
				e = $urandom_range(0, n - 1);
				t = $urandom_range(0, 1024);
				ex = lx[e] + (lx[(e + 1) % n] - lx[e]) * t / 1024
					+ $signed($urandom_range(0, span / 4)) - span / 8;
				ey = ly[e] + (ly[(e + 1) % n] - ly[e]) * t / 1024
					+ $signed($urandom_range(0, span / 4)) - span / 8;
				send(MODE_QUERY, 6'($urandom), sat24(ex), sat24(ey),
					23'($urandom_range(0, span / 3)));
			end
			if (sb.n_queries > 700 && sb.n_queries < 715) drain();
		end

		drain();
		repeat (50) @(posedge clk);
		$display("%0d vertex loads, %0d queries; results none/one/two/ack: %0d/%0d/%0d/%0d",
			sb.n_loads, sb.n_queries, sb.n_kind[0], sb.n_kind[1], sb.n_kind[2], sb.n_kind[3]);
		if (sb.pending_hits.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.pending_hits.size()));
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/pcc_pkg.sv
src/pcc_vmem.sv
src/pcc_alu.sv
src/polygon_circle_collision_top.sv
tb/polygon_circle_collision_top_tb.sv
